/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* design/gtz_pkg.sv */
// ----------------------------------------------------------------------------
// gtz_pkg
// Shared types, register codes and the Q2.29 coefficient multiply.
// ----------------------------------------------------------------------------
package gtz_pkg;

    localparam int COEF_W     = 32;
    localparam int STATE_W    = 64;
    localparam int LEN_W      = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int Q_SHIFT    = 29;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TWO_COS = 3'd0,
        REG_COS     = 3'd1,
        REG_SIN     = 3'd2,
        REG_WINDOW  = 3'd3,
        REG_USED    = 3'd4
    } t_reg_index;

    localparam logic [COEF_W-1:0] RST_TWO_COS = 32'h4000_0000;
    localparam logic [COEF_W-1:0] RST_COS     = 32'h2000_0000;
    localparam logic [COEF_W-1:0] RST_SIN     = 32'h0000_0000;
    localparam logic [LEN_W-1:0]  RST_WINDOW  = 16'd1024;
    localparam logic [LEN_W-1:0]  RST_USED    = 16'd1024;

    typedef struct packed {
        logic [COEF_W-1:0] two_cos;
        logic [COEF_W-1:0] cos_w;
        logic [COEF_W-1:0] sin_w;
        logic [LEN_W-1:0]  window_length;
        logic [LEN_W-1:0]  used_length;
    } t_cfg;

    // Final state of a finished window on its way to the output stage.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] s1;
        logic [STATE_W-1:0] s2;
    } t_end;

    // floor(coef * s / 2^29), wrapped to 64 bits. The 64-bit state is split
    // in a signed upper and an unsigned lower half: a 32x32 and a 32x33 product.
    function automatic logic [STATE_W-1:0] mul_q29(input logic [STATE_W-1:0] s,
                                                   input logic [COEF_W-1:0]  c);
        logic signed [STATE_W-1:0] ph;
        logic signed [STATE_W-1:0] pl;
        ph = $signed(c) * $signed(s[STATE_W-1:COEF_W]);
        pl = $signed(c) * $signed({1'b0, s[COEF_W-1:0]});
        return $unsigned((ph <<< (COEF_W - Q_SHIFT)) + (pl >>> Q_SHIFT));
    endfunction

endpackage

/* design/gtz_cfg.sv */
// ----------------------------------------------------------------------------
// gtz_cfg
// Configuration register file; flags a run clear on every valid write to a known register.
// ----------------------------------------------------------------------------
module gtz_cfg
    import gtz_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg,
    output logic                 o_clear
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_write;

    assign o_cfg_ready = 1'b1;
    assign w_write     = i_cfg_valid && o_cfg_ready;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (i_cfg_index)
                REG_TWO_COS: n_cfg.two_cos       = i_cfg_data;
                REG_COS:     n_cfg.cos_w         = i_cfg_data;
                REG_SIN:     n_cfg.sin_w         = i_cfg_data;
                REG_WINDOW:  n_cfg.window_length = i_cfg_data[LEN_W-1:0];
                REG_USED:    n_cfg.used_length   = i_cfg_data[LEN_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    // Unknown indexes are dropped and leave the running window alone.
    assign o_clear = w_write &&
                     (i_cfg_index inside {REG_TWO_COS, REG_COS, REG_SIN, REG_WINDOW, REG_USED});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{two_cos: RST_TWO_COS, cos_w: RST_COS, sin_w: RST_SIN,
                       window_length: RST_WINDOW, used_length: RST_USED};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* design/gtz_recur.sv */
// ----------------------------------------------------------------------------
// gtz_recur
// Input register, Goertzel recurrence and window counter.
// ----------------------------------------------------------------------------
module gtz_recur
    import gtz_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  t_cfg                   i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output t_end                   o_end,
    input  logic                   i_end_ready
);

    localparam int CMP_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;
    localparam logic [CMP_W-1:0] COUNT_MAX =
        {{(CMP_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic                   r_in_valid, n_in_valid;
    logic [SAMPLE_BITS-1:0] r_sample,   n_sample;
    logic [STATE_W-1:0]     r_s1,       n_s1;
    logic [STATE_W-1:0]     r_s2,       n_s2;
    logic [COUNT_BITS-1:0]  r_count,    n_count;
    logic                   r_end_valid, n_end_valid;
    logic [STATE_W-1:0]     r_end_s1,   n_end_s1;
    logic [STATE_W-1:0]     r_end_s2,   n_end_s2;

    logic               w_advance;
    logic [CMP_W-1:0]   w_count_ext, w_next_ext, w_used_ext, w_win_raw, w_win;
    logic               w_use, w_win_end;
    logic [STATE_W-1:0] w_x, w_s0, w_upd_s1, w_upd_s2;

    // Window bookkeeping, compared one bit wider than both operands.
    assign w_count_ext = CMP_W'(r_count);
    assign w_next_ext  = w_count_ext + CMP_W'(1);
    assign w_used_ext  = CMP_W'(i_cfg.used_length);
    assign w_win_raw   = CMP_W'(i_cfg.window_length);
    assign w_win       = (w_win_raw > COUNT_MAX) ? COUNT_MAX : w_win_raw;
    assign w_use       = w_count_ext < w_used_ext;
    assign w_win_end   = w_next_ext >= w_win;

    // s0 = x + 2cos*s1 - s2, sample placed at Q47.16.
    assign w_x      = STATE_W'(r_sample) << FRAC_SHIFT;
    assign w_s0     = w_x + mul_q29(r_s1, i_cfg.two_cos) - r_s2;
    assign w_upd_s1 = w_use ? w_s0 : r_s1;
    assign w_upd_s2 = w_use ? r_s1 : r_s2;

    assign w_advance  = r_in_valid && (!r_end_valid || i_end_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_sample    = r_sample;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_count     = r_count;
        n_end_valid = r_end_valid;
        n_end_s1    = r_end_s1;
        n_end_s2    = r_end_s2;

        if (i_end_ready) begin
            n_end_valid = 1'b0;
        end
        if (w_advance) begin
            n_in_valid = 1'b0;
            if (w_win_end) begin
                n_end_valid = 1'b1;
                n_end_s1    = w_upd_s1;
                n_end_s2    = w_upd_s2;
                n_s1        = '0;
                n_s2        = '0;
                n_count     = '0;
            end else begin
                n_s1    = w_upd_s1;
                n_s2    = w_upd_s2;
                n_count = w_next_ext[COUNT_BITS-1:0];
            end
        end
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_sample   = i_sample;
        end
        if (i_clear) begin
            n_s1    = '0;
            n_s2    = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_end_valid <= 1'b0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_count     <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_end_valid <= n_end_valid;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_end_s1 <= n_end_s1;
        r_end_s2 <= n_end_s2;
    end

    assign o_end = '{valid: r_end_valid, s1: r_end_s1, s2: r_end_s2};

endmodule

/* design/gtz_iq_out.sv */
// ----------------------------------------------------------------------------
// gtz_iq_out
// Forms re = s1*cos - s2 and im = s1*sin into the output register.
// ----------------------------------------------------------------------------
module gtz_iq_out
    import gtz_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_end               i_end,
    output logic               o_end_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STATE_W-1:0] o_real_part,
    output logic [STATE_W-1:0] o_imag_part
);

    logic               r_out_valid, n_out_valid;
    logic [STATE_W-1:0] r_real,      n_real;
    logic [STATE_W-1:0] r_imag,      n_imag;

    assign o_end_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_real      = r_real;
        n_imag      = r_imag;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_end.valid && o_end_ready) begin
            n_out_valid = 1'b1;
            n_real      = mul_q29(i_end.s1, i_cfg.cos_w) - i_end.s2;
            n_imag      = mul_q29(i_end.s1, i_cfg.sin_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_real <= n_real;
        r_imag <= n_imag;
    end

    assign o_out_valid = r_out_valid;
    assign o_real_part = r_real;
    assign o_imag_part = r_imag;

endmodule

/* design/goertzel_iq_demodulator.sv */
// ----------------------------------------------------------------------------
// goertzel_iq_demodulator
// Single-bin Goertzel detector: ADC samples in, one I/Q pair per window out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_sample): one ADC sample per
//   transfer. One sample per cycle is sustained while the output side does not stall;
//   the recurrence for a sample is computed from the input register and committed when it moves on.
//   Output channel (o_out_valid / i_out_ready / o_real_part / o_imag_part):
//   one transfer per window, signed Q47.16. A window's last sample passes from the input
//   register through the end-of-window stage, and its result into the output register.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready. Any write to a known register also restarts the window
//   (state and sample count cleared); unknown indexes are ignored. Write
//   only while the block is idle.
//   Stalls: the end-of-window stage and the output register buffer two
//   results, so samples keep flowing while a result waits; once both are
//   full the input channel stalls.
//   Reset (i_rst_n low, synchronous): registers return to their defaults,
//   the window restarts and no result is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module goertzel_iq_demodulator
    import gtz_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample stream
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // I/Q results
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [STATE_W-1:0]     o_real_part,
    output logic [STATE_W-1:0]     o_imag_part,
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COEF_W-1:0]      i_cfg_data
);

    t_cfg w_cfg;
    logic w_clear;
    t_end w_end;
    logic w_end_ready;

    // Coefficients and window lengths; a write to a known register restarts the run.
    gtz_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_clear     (w_clear)
    );

    // Input register + recurrence; hands off final s1/s2 at window end.
    gtz_recur #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_recur (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clear),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_end       (w_end),
        .i_end_ready (w_end_ready)
    );

    // Final rotation into the output register.
    gtz_iq_out u_iq_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_end       (w_end),
        .o_end_ready (w_end_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_real_part (o_real_part),
        .o_imag_part (o_imag_part)
    );

    // Reset leaves no result pending.
    `ASSERT_ALWAYS(a_rst_no_result, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // A finished window that cannot move on must stay in its stage.
    `ASSERT_CLK(a_end_held, (w_end.valid && !w_end_ready) |=> w_end.valid, "window result lost")
    // With nothing behind it, a taken result leaves the output empty.
    `ASSERT_CLK(a_out_drains, (o_out_valid && i_out_ready && !w_end.valid) |=> !o_out_valid,
                "result repeated")

endmodule
